// ===== design/curved_capsule_inside_project_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the curved capsule point query block
// Implication and next-cycle checks, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef CURVED_CAPSULE_INSIDE_PROJECT_MACROS_SVH
`define CURVED_CAPSULE_INSIDE_PROJECT_MACROS_SVH
`ifndef SYNTHESIS
`define CCIP_ASSERT_IMP(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("ccip: same-cycle check failed");
`define CCIP_ASSERT_NEXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("ccip: next-cycle check failed");
`else
`define CCIP_ASSERT_IMP(lbl, ck, rn, pre, post)
`define CCIP_ASSERT_NEXT(lbl, ck, rn, pre, post)
`endif
`endif

// ===== design/ccip_pkg.sv =====
// ----------------------------------------------------------------------------
// Curved capsule package
// Word types, register indexes, reset values and pipeline depths.
// ----------------------------------------------------------------------------
package ccip_pkg;

  // Number of spatial dimensions; with two, pos_z is ignored.
  localparam int DIMENSIONS = 3;

  // One stage per result bit in the root and quotient pipelines.
  localparam int SQ_LAT  = 32;
  localparam int DIV_LAT = 31;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARC_RADIUS = 3'd0,
    CFG_TUBE_WIDTH = 3'd1,
    CFG_CENTER_Y   = 3'd2,
    CFG_END_X      = 3'd3,
    CFG_END_Y      = 3'd4
  } cfg_idx_t;

  localparam logic [30:0]        RST_ARC_RADIUS = 31'd1310720;
  localparam logic [30:0]        RST_TUBE_WIDTH = 31'd131072;
  localparam logic signed [31:0] RST_CENTER_Y   = 32'sd0;
  localparam logic [30:0]        RST_END_X      = 31'd0;
  localparam logic signed [31:0] RST_END_Y      = 32'sd0;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic               is_inside;
    logic signed [31:0] surf_x;
    logic signed [31:0] surf_y;
    logic signed [31:0] surf_z;
    logic               degenerate;
  } out_word_t;

endpackage

// ===== design/ccip_in_if.sv =====
// ----------------------------------------------------------------------------
// Point input channel
// Valid/ready channel carrying one query point per word.
// ----------------------------------------------------------------------------
interface ccip_in_if;
  logic               valid;
  logic               ready;
  ccip_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ccip_out_if.sv =====
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one query result per word.
// ----------------------------------------------------------------------------
interface ccip_out_if;
  logic                valid;
  logic                ready;
  ccip_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ccip_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor root of a 64-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module ccip_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  logic [63:0] rem_r   [ccip_pkg::SQ_LAT];
  logic [63:0] res_r   [ccip_pkg::SQ_LAT];
  logic [63:0] rem_nxt [ccip_pkg::SQ_LAT];
  logic [63:0] res_nxt [ccip_pkg::SQ_LAT];

  always_comb begin
    logic [63:0] rem_in;
    logic [63:0] res_in;
    logic [63:0] bit_c;
    logic [63:0] trial;
    for (int i = 0; i < ccip_pkg::SQ_LAT; i++) begin
      if (i == 0) begin
        rem_in = rad_i;
        res_in = '0;
      end else begin
        rem_in = rem_r[i-1];
        res_in = res_r[i-1];
      end
      bit_c = 64'd1 << (2 * (ccip_pkg::SQ_LAT - 1 - i));
      trial = res_in + bit_c;
      if (rem_in >= trial) begin
        rem_nxt[i] = rem_in - trial;
        res_nxt[i] = (res_in >> 1) + bit_c;
      end else begin
        rem_nxt[i] = rem_in;
        res_nxt[i] = res_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

  assign root_o = res_r[ccip_pkg::SQ_LAT-1][31:0];

endmodule

// ===== design/ccip_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// 62-bit dividend over a 32-bit divisor, quotient known to fit 31 bits.
// ----------------------------------------------------------------------------
module ccip_div (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] num_i,
  input  logic [31:0] den_i,
  output logic [30:0] quo_o
);

  logic [31:0] rem_r   [ccip_pkg::DIV_LAT];
  logic [30:0] low_r   [ccip_pkg::DIV_LAT];
  logic [30:0] quo_r   [ccip_pkg::DIV_LAT];
  logic [31:0] den_r   [ccip_pkg::DIV_LAT];
  logic [31:0] rem_nxt [ccip_pkg::DIV_LAT];
  logic [30:0] low_nxt [ccip_pkg::DIV_LAT];
  logic [30:0] quo_nxt [ccip_pkg::DIV_LAT];
  logic [31:0] den_nxt [ccip_pkg::DIV_LAT];

  // The upper dividend bits start out below the divisor because the
  // quotient is known to fit, so each stage only decides one bit.
  always_comb begin
    logic [31:0] rem_in;
    logic [30:0] low_in;
    logic [30:0] quo_in;
    logic [31:0] den_in;
    logic [32:0] trial;
    logic        ge;
    for (int i = 0; i < ccip_pkg::DIV_LAT; i++) begin
      if (i == 0) begin
        rem_in = {1'b0, num_i[61:31]};
        low_in = num_i[30:0];
        quo_in = '0;
        den_in = den_i;
      end else begin
        rem_in = rem_r[i-1];
        low_in = low_r[i-1];
        quo_in = quo_r[i-1];
        den_in = den_r[i-1];
      end
      trial = {rem_in, low_in[30]};
      ge    = trial >= {1'b0, den_in};
      rem_nxt[i] = ge ? 32'(trial - {1'b0, den_in}) : trial[31:0];
      low_nxt[i] = {low_in[29:0], 1'b0};
      quo_nxt[i] = {quo_in[29:0], ge};
      den_nxt[i] = den_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      quo_r <= quo_nxt;
      den_r <= den_nxt;
    end
  end

  assign quo_o = quo_r[ccip_pkg::DIV_LAT-1];

endmodule

// ===== design/curved_capsule_inside_project.sv =====
// ----------------------------------------------------------------------------
// Curved capsule point query
// Projects a point onto an arc backbone and its tube surface, fully pipelined.
// ----------------------------------------------------------------------------
// Usage. Points arrive as words on in_ch (pos_x, pos_y, pos_z, signed Q16.16)
// and one result word per point leaves on out_ch (is_inside, surf_x, surf_y,
// surf_z, degenerate), in the same order. A word moves at a rising clock edge
// where valid and ready are both high.
// The shape registers are written through cfg_we, cfg_idx and cfg_data while
// no point is in flight; index order is arc_radius, tube_width, center_y,
// end_x, end_y, and other indexes are ignored.
// Throughput is one word per cycle while out_ch does not stall. The accepting
// edge loads the first of 139 register stages: two 32-stage root pipelines
// and two 31-stage quotient pipelines, one of each per normalization, plus
// thirteen stages of subtract, multiply, clamp and output, the last of which
// is the output register that holds the result of a point.
// The whole pipeline advances on one enable: it moves whenever the output
// register is empty or being taken, so in_ch.ready follows out_ch.ready while
// a result waits and a stall freezes every stage without loss or repeat.
// Reset is synchronous and active low; it clears all valid bits and loads the
// shape registers with their defaults (radius 20.0, tube width 2.0, rest 0).
// ----------------------------------------------------------------------------
`include "curved_capsule_inside_project_macros.svh"

module curved_capsule_inside_project (
  input  logic                                clk,
  input  logic                                rst_n,
  ccip_in_if.sink                             in_ch,
  ccip_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [ccip_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ccip_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Front stages: radial offset from the arc center.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [1:0][32:0]   cm;
    logic [1:0]         cn;
  } s1_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [1:0][30:0]   a;
    logic [1:0]         cn;
  } s2_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [1:0][30:0]   a;
    logic [1:0]         cn;
    logic [1:0][61:0]   sq;
  } s3_t;

  // Travels beside the first root pipeline.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [1:0][30:0]   a;
    logic [1:0]         cn;
  } side_a_t;

  // Travels beside the first quotient pipelines.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [1:0]         cn;
    logic               dg1;
  } side_b_t;

  // Backbone point before and after the clamp to the arc end.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [32:0] bx;
    logic signed [33:0] by;
    logic               dg1;
  } side_c_t;

  typedef struct packed {
    logic               valid;
    logic [2:0][33:0]   m;
    logic [2:0]         n;
    logic signed [32:0] bx;
    logic signed [33:0] by;
    logic               dg1;
  } side_d_t;

  typedef struct packed {
    logic               valid;
    logic [2:0][30:0]   e;
    logic [2:0][30:0]   cm;
    logic               pre;
    logic [2:0]         n;
    logic signed [32:0] bx;
    logic signed [33:0] by;
    logic               dg1;
  } side_e_t;

  typedef struct packed {
    logic               valid;
    logic [2:0][61:0]   esq;
    logic [2:0][61:0]   cmsq;
    logic [61:0]        ww;
    logic               pre;
    logic [2:0][30:0]   e;
    logic [2:0]         n;
    logic signed [32:0] bx;
    logic signed [33:0] by;
    logic               dg1;
  } side_f_t;

  // Travels beside the second root pipeline.
  typedef struct packed {
    logic               valid;
    logic [2:0][30:0]   e;
    logic [2:0]         n;
    logic signed [32:0] bx;
    logic signed [33:0] by;
    logic               dg1;
    logic               in_tube;
  } side_g_t;

  // Travels beside the second quotient pipelines.
  typedef struct packed {
    logic               valid;
    logic [2:0]         n;
    logic signed [32:0] bx;
    logic signed [33:0] by;
    logic               dg1;
    logic               in_tube;
    logic               dg2;
  } side_h_t;

  // Shape registers.
  logic [30:0]        arc_radius_r;
  logic [30:0]        tube_width_r;
  logic signed [31:0] center_y_r;
  logic [30:0]        end_x_r;
  logic signed [31:0] end_y_r;

  logic adv;

  s1_t     s1_r, s1_nxt;
  s2_t     s2_r, s2_nxt;
  s3_t     s3_r, s3_nxt;
  side_a_t s4_r, s4_nxt;
  logic [63:0] sum1_r, sum1_nxt;
  side_a_t line1_r [ccip_pkg::SQ_LAT];
  logic [31:0] root1;

  side_b_t sm_r, sm_nxt;
  logic [1:0][61:0] num1_r, num1_nxt;
  logic [31:0]      nrm1_r;
  side_b_t line2_r [ccip_pkg::DIV_LAT];
  logic [1:0][30:0] q1;

  side_c_t p1_r, p1_nxt;
  side_c_t p2_r, p2_nxt;
  side_d_t p3_r, p3_nxt;
  side_e_t p4_r, p4_nxt;
  side_f_t p5_r, p5_nxt;
  side_g_t p6_r, p6_nxt;
  logic [63:0] sum2_r, sum2_nxt;
  side_g_t line3_r [ccip_pkg::SQ_LAT];
  logic [31:0] root2;

  side_h_t qs_r, qs_nxt;
  logic [2:0][61:0] num2_r, num2_nxt;
  logic [31:0]      nrm2_r;
  side_h_t line4_r [ccip_pkg::DIV_LAT];
  logic [2:0][30:0] q2;

  ccip_pkg::out_word_t out_word_r, out_word_nxt;
  logic                out_valid_r;

  logic [ccip_pkg::SQ_LAT-1:0] line3_valid;
  logic                        root1_ok;
  logic                        root2_ok;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // Shape register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arc_radius_r <= ccip_pkg::RST_ARC_RADIUS;
      tube_width_r <= ccip_pkg::RST_TUBE_WIDTH;
      center_y_r   <= ccip_pkg::RST_CENTER_Y;
      end_x_r      <= ccip_pkg::RST_END_X;
      end_y_r      <= ccip_pkg::RST_END_Y;
    end else if (cfg_we) begin
      case (cfg_idx)
        ccip_pkg::CFG_ARC_RADIUS: arc_radius_r <= cfg_data[30:0];
        ccip_pkg::CFG_TUBE_WIDTH: tube_width_r <= cfg_data[30:0];
        ccip_pkg::CFG_CENTER_Y:   center_y_r   <= $signed(cfg_data);
        ccip_pkg::CFG_END_X:      end_x_r      <= cfg_data[30:0];
        ccip_pkg::CFG_END_Y:      end_y_r      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Radial offset (x, y - center_y) as magnitude and sign.
  always_comb begin
    logic signed [32:0] c0;
    logic signed [32:0] c1;
    s1_nxt.valid = in_ch.valid;
    s1_nxt.px    = in_ch.data.pos_x;
    s1_nxt.py    = in_ch.data.pos_y;
    s1_nxt.pz    = (ccip_pkg::DIMENSIONS > 2) ? in_ch.data.pos_z : 32'sd0;
    c0 = {in_ch.data.pos_x[31], in_ch.data.pos_x};
    c1 = {in_ch.data.pos_y[31], in_ch.data.pos_y} - {center_y_r[31], center_y_r};
    s1_nxt.cn[0] = c0[32];
    s1_nxt.cn[1] = c1[32];
    s1_nxt.cm[0] = c0[32] ? 33'(-c0) : 33'(c0);
    s1_nxt.cm[1] = c1[32] ? 33'(-c1) : 33'(c1);
  end

  // The offset never reaches 2^32, so at most one halving brings both
  // components below 2^31.
  always_comb begin
    logic        fsh;
    logic [32:0] cor;
    cor          = s1_r.cm[0] | s1_r.cm[1];
    fsh          = |cor[32:31];
    s2_nxt.valid = s1_r.valid;
    s2_nxt.px    = s1_r.px;
    s2_nxt.py    = s1_r.py;
    s2_nxt.pz    = s1_r.pz;
    s2_nxt.cn    = s1_r.cn;
    for (int k = 0; k < 2; k++) begin
      s2_nxt.a[k] = fsh ? s1_r.cm[k][31:1] : s1_r.cm[k][30:0];
    end
  end

  always_comb begin
    s3_nxt.valid = s2_r.valid;
    s3_nxt.px    = s2_r.px;
    s3_nxt.py    = s2_r.py;
    s3_nxt.pz    = s2_r.pz;
    s3_nxt.a     = s2_r.a;
    s3_nxt.cn    = s2_r.cn;
    for (int k = 0; k < 2; k++) begin
      s3_nxt.sq[k] = 62'(s2_r.a[k]) * 62'(s2_r.a[k]);
    end
  end

  always_comb begin
    s4_nxt.valid = s3_r.valid;
    s4_nxt.px    = s3_r.px;
    s4_nxt.py    = s3_r.py;
    s4_nxt.pz    = s3_r.pz;
    s4_nxt.a     = s3_r.a;
    s4_nxt.cn    = s3_r.cn;
    sum1_nxt     = 64'(s3_r.sq[0]) + 64'(s3_r.sq[1]);
  end

  ccip_sqrt u_sqrt_radial (
    .clk    (clk),
    .en     (adv),
    .rad_i  (sum1_r),
    .root_o (root1)
  );

  // Scaled radial components arc_radius * |c| ahead of the division.
  always_comb begin
    side_a_t l1;
    l1           = line1_r[ccip_pkg::SQ_LAT-1];
    sm_nxt.valid = l1.valid;
    sm_nxt.px    = l1.px;
    sm_nxt.py    = l1.py;
    sm_nxt.pz    = l1.pz;
    sm_nxt.cn    = l1.cn;
    sm_nxt.dg1   = (root1 == 32'd0);
    for (int k = 0; k < 2; k++) begin
      num1_nxt[k] = 62'(arc_radius_r) * 62'(l1.a[k]);
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_div_radial
    ccip_div u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (num1_r[k]),
      .den_i (nrm1_r),
      .quo_o (q1[k])
    );
  end

  // Backbone point on the circle; a point on the axis falls back to the
  // arc center.
  always_comb begin
    side_b_t            l2;
    logic signed [32:0] qx;
    logic signed [33:0] qy;
    l2           = line2_r[ccip_pkg::DIV_LAT-1];
    qx           = {2'b00, q1[0]};
    qy           = {3'b000, q1[1]};
    p1_nxt.valid = l2.valid;
    p1_nxt.px    = l2.px;
    p1_nxt.py    = l2.py;
    p1_nxt.pz    = l2.pz;
    p1_nxt.dg1   = l2.dg1;
    if (l2.dg1) begin
      p1_nxt.bx = 33'sd0;
      p1_nxt.by = {{2{center_y_r[31]}}, center_y_r};
    end else begin
      p1_nxt.bx = l2.cn[0] ? -qx : qx;
      p1_nxt.by = {{2{center_y_r[31]}}, center_y_r} + (l2.cn[1] ? -qy : qy);
    end
  end

  // Beyond the end height the backbone point snaps to the arc end on the
  // side of the point; zero x takes the positive end.
  always_comb begin
    logic signed [32:0] ex;
    ex     = {2'b00, end_x_r};
    p2_nxt = p1_r;
    if ($signed(p1_r.by) > $signed({{2{end_y_r[31]}}, end_y_r})) begin
      p2_nxt.bx = p1_r.px[31] ? -ex : ex;
      p2_nxt.by = {{2{end_y_r[31]}}, end_y_r};
    end
  end

  // Offset from the backbone point.
  always_comb begin
    logic signed [34:0] d [3];
    d[0] = {{3{p2_r.px[31]}}, p2_r.px} - {{2{p2_r.bx[32]}}, p2_r.bx};
    d[1] = {{3{p2_r.py[31]}}, p2_r.py} - {p2_r.by[33], p2_r.by};
    d[2] = {{3{p2_r.pz[31]}}, p2_r.pz};
    p3_nxt.valid = p2_r.valid;
    p3_nxt.bx    = p2_r.bx;
    p3_nxt.by    = p2_r.by;
    p3_nxt.dg1   = p2_r.dg1;
    for (int k = 0; k < 3; k++) begin
      p3_nxt.n[k] = d[k][34];
      p3_nxt.m[k] = d[k][34] ? 34'(-d[k]) : d[k][33:0];
    end
  end

  // The containment test is exact: it only needs squares when every
  // component already lies within the tube width. The normalization path
  // halves the offset until it fits 31 bits.
  always_comb begin
    logic [33:0] mor;
    logic [1:0]  fsh;
    logic        pre;
    mor = p3_r.m[0] | p3_r.m[1] | p3_r.m[2];
    if (mor[33]) begin
      fsh = 2'd3;
    end else if (mor[32]) begin
      fsh = 2'd2;
    end else if (mor[31]) begin
      fsh = 2'd1;
    end else begin
      fsh = 2'd0;
    end
    pre = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (p3_r.m[k] > {3'b000, tube_width_r}) begin
        pre = 1'b0;
      end
    end
    p4_nxt.valid = p3_r.valid;
    p4_nxt.pre   = pre;
    p4_nxt.n     = p3_r.n;
    p4_nxt.bx    = p3_r.bx;
    p4_nxt.by    = p3_r.by;
    p4_nxt.dg1   = p3_r.dg1;
    for (int k = 0; k < 3; k++) begin
      p4_nxt.e[k]  = 31'(p3_r.m[k] >> fsh);
      p4_nxt.cm[k] = pre ? p3_r.m[k][30:0] : 31'd0;
    end
  end

  always_comb begin
    p5_nxt.valid = p4_r.valid;
    p5_nxt.pre   = p4_r.pre;
    p5_nxt.e     = p4_r.e;
    p5_nxt.n     = p4_r.n;
    p5_nxt.bx    = p4_r.bx;
    p5_nxt.by    = p4_r.by;
    p5_nxt.dg1   = p4_r.dg1;
    p5_nxt.ww    = 62'(tube_width_r) * 62'(tube_width_r);
    for (int k = 0; k < 3; k++) begin
      p5_nxt.esq[k]  = 62'(p4_r.e[k]) * 62'(p4_r.e[k]);
      p5_nxt.cmsq[k] = 62'(p4_r.cm[k]) * 62'(p4_r.cm[k]);
    end
  end

  always_comb begin
    logic [63:0] cmsum;
    cmsum = 64'(p5_r.cmsq[0]) + 64'(p5_r.cmsq[1]) + 64'(p5_r.cmsq[2]);
    sum2_nxt = 64'(p5_r.esq[0]) + 64'(p5_r.esq[1]) + 64'(p5_r.esq[2]);
    p6_nxt.valid   = p5_r.valid;
    p6_nxt.e       = p5_r.e;
    p6_nxt.n       = p5_r.n;
    p6_nxt.bx      = p5_r.bx;
    p6_nxt.by      = p5_r.by;
    p6_nxt.dg1     = p5_r.dg1;
    p6_nxt.in_tube = p5_r.pre && (cmsum <= 64'(p5_r.ww));
  end

  ccip_sqrt u_sqrt_surface (
    .clk    (clk),
    .en     (adv),
    .rad_i  (sum2_r),
    .root_o (root2)
  );

  always_comb begin
    side_g_t l3;
    l3             = line3_r[ccip_pkg::SQ_LAT-1];
    qs_nxt.valid   = l3.valid;
    qs_nxt.n       = l3.n;
    qs_nxt.bx      = l3.bx;
    qs_nxt.by      = l3.by;
    qs_nxt.dg1     = l3.dg1;
    qs_nxt.in_tube = l3.in_tube;
    qs_nxt.dg2     = (root2 == 32'd0);
    for (int k = 0; k < 3; k++) begin
      num2_nxt[k] = 62'(tube_width_r) * 62'(l3.e[k]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div_surface
    ccip_div u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (num2_r[k]),
      .den_i (nrm2_r),
      .quo_o (q2[k])
    );
  end

  // Surface point; a point on the backbone reports the backbone point.
  always_comb begin
    side_h_t            l4;
    logic signed [34:0] qv [3];
    logic signed [34:0] sx;
    logic signed [34:0] sy;
    logic signed [34:0] sz;
    l4 = line4_r[ccip_pkg::DIV_LAT-1];
    for (int k = 0; k < 3; k++) begin
      qv[k] = l4.n[k] ? -$signed({4'b0000, q2[k]}) : $signed({4'b0000, q2[k]});
    end
    if (l4.dg2) begin
      sx = {{2{l4.bx[32]}}, l4.bx};
      sy = {l4.by[33], l4.by};
      sz = 35'sd0;
    end else begin
      sx = {{2{l4.bx[32]}}, l4.bx} + qv[0];
      sy = {l4.by[33], l4.by} + qv[1];
      sz = qv[2];
    end
    out_word_nxt.is_inside  = l4.in_tube;
    out_word_nxt.surf_x     = sat32(sx);
    out_word_nxt.surf_y     = sat32(sy);
    out_word_nxt.surf_z     = sat32(sz);
    out_word_nxt.degenerate = l4.dg1 | l4.dg2;
  end

  // All stages share the advance enable; reset clears only valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid  <= 1'b0;
      s2_r.valid  <= 1'b0;
      s3_r.valid  <= 1'b0;
      s4_r.valid  <= 1'b0;
      sm_r.valid  <= 1'b0;
      p1_r.valid  <= 1'b0;
      p2_r.valid  <= 1'b0;
      p3_r.valid  <= 1'b0;
      p4_r.valid  <= 1'b0;
      p5_r.valid  <= 1'b0;
      p6_r.valid  <= 1'b0;
      qs_r.valid  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ccip_pkg::SQ_LAT; i++) begin
        line1_r[i].valid <= 1'b0;
        line3_r[i].valid <= 1'b0;
      end
      for (int i = 0; i < ccip_pkg::DIV_LAT; i++) begin
        line2_r[i].valid <= 1'b0;
        line4_r[i].valid <= 1'b0;
      end
    end else if (adv) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      s3_r   <= s3_nxt;
      s4_r   <= s4_nxt;
      sum1_r <= sum1_nxt;
      line1_r[0] <= s4_r;
      line3_r[0] <= p6_r;
      for (int i = 1; i < ccip_pkg::SQ_LAT; i++) begin
        line1_r[i] <= line1_r[i-1];
        line3_r[i] <= line3_r[i-1];
      end
      sm_r   <= sm_nxt;
      num1_r <= num1_nxt;
      nrm1_r <= root1;
      line2_r[0] <= sm_r;
      line4_r[0] <= qs_r;
      for (int i = 1; i < ccip_pkg::DIV_LAT; i++) begin
        line2_r[i] <= line2_r[i-1];
        line4_r[i] <= line4_r[i-1];
      end
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      p3_r   <= p3_nxt;
      p4_r   <= p4_nxt;
      p5_r   <= p5_nxt;
      p6_r   <= p6_nxt;
      sum2_r <= sum2_nxt;
      qs_r   <= qs_nxt;
      num2_r <= num2_nxt;
      nrm2_r <= root2;
      out_word_r  <= out_word_nxt;
      out_valid_r <= line4_r[ccip_pkg::DIV_LAT-1].valid;
    end
  end

  always_comb begin
    for (int i = 0; i < ccip_pkg::SQ_LAT; i++) begin
      line3_valid[i] = line3_r[i].valid;
    end
  end

  // Each root must cover every component of the vector it came from.
  always_comb begin
    side_a_t t1;
    side_g_t t3;
    t1 = line1_r[ccip_pkg::SQ_LAT-1];
    t3 = line3_r[ccip_pkg::SQ_LAT-1];
    root1_ok = (root1 >= 32'(t1.a[0])) && (root1 >= 32'(t1.a[1]));
    root2_ok = (root2 >= 32'(t3.e[0])) && (root2 >= 32'(t3.e[1])) &&
               (root2 >= 32'(t3.e[2]));
  end

  // A root that lines up with its side data is never below any component.
  `CCIP_ASSERT_IMP(a_root_radial_bound, clk, rst_n, line1_r[ccip_pkg::SQ_LAT-1].valid, root1_ok)
  `CCIP_ASSERT_IMP(a_root_surface_bound, clk, rst_n, line3_r[ccip_pkg::SQ_LAT-1].valid, root2_ok)
  // A stall freezes the occupancy of the second root pipeline's side line.
  `CCIP_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !adv, $stable(line3_valid))

endmodule
